### src/elgamal_decrypt_assert.svh
// Assertion macros for the ElGamal decryption unit.
// Included by the top level; no other dependencies.
`ifndef ELGAMAL_DECRYPT_ASSERT_SVH
`define ELGAMAL_DECRYPT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EGD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EGD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EGD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define EGD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/egd_pkg.sv
// Shared types and constants of the ElGamal decryption unit.
// No dependencies.
package egd_pkg;
    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned REG_BITS = 32;
    localparam int unsigned IDX_BITS = 1;
    localparam logic [IDX_BITS-1:0] REG_MODULUS = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_EXPONENT = 1'b1;
    localparam logic [REG_BITS-1:0] MODULUS_RESET = 32'd23;
    localparam logic [REG_BITS-1:0] EXPONENT_RESET = 32'd1;

    // Datapath operation codes.
    localparam int unsigned OP_BITS = 3;
    localparam logic [OP_BITS-1:0] OP_LOAD = 3'd0;
    localparam logic [OP_BITS-1:0] OP_REDUCE = 3'd1;
    localparam logic [OP_BITS-1:0] OP_MUL = 3'd2;
    localparam logic [OP_BITS-1:0] OP_SQR = 3'd3;
    localparam logic [OP_BITS-1:0] OP_DIV = 3'd4;
    localparam logic [OP_BITS-1:0] OP_QMUL = 3'd5;
    localparam logic [OP_BITS-1:0] OP_STEP = 3'd6;
    localparam logic [OP_BITS-1:0] OP_MSG = 3'd7;

    typedef struct packed {
        logic                go;
        logic [OP_BITS-1:0]  op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic mod_zero;
        logic exp_zero;
        logic exp_bit;
        logic r1_zero;
        logic r0_one;
    } t_status;
endpackage

### src/egd_ctrl.sv
// Controller of the ElGamal decryption unit: sequences the datapath.
// Depends on egd_pkg.
module egd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  egd_pkg::t_status   i_status,
    output egd_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_valid,
    output logic               o_fail
);
    import egd_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RED  = 4'd1;
    localparam logic [3:0] S_EXP  = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_SQR  = 4'd4;
    localparam logic [3:0] S_EUC  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_QMUL = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_MSG  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_issued, n_issued;
    logic       r_fail, n_fail;

    always_comb begin
        n_state  = r_state;
        n_issued = r_issued;
        n_fail   = r_fail;
        o_cmd    = '{go: 1'b0, op: OP_LOAD};
        o_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd   = '{go: 1'b1, op: OP_LOAD};
                    n_fail  = 1'b0;
                    n_state = S_RED;
                end
            end
            S_RED, S_MUL, S_SQR, S_DIV, S_QMUL, S_MSG: begin
                if (!r_issued) begin
                    n_issued = 1'b1;
                    priority case (r_state)
                        S_RED:  o_cmd = '{go: 1'b1, op: OP_REDUCE};
                        S_MUL:  o_cmd = '{go: 1'b1, op: OP_MUL};
                        S_SQR:  o_cmd = '{go: 1'b1, op: OP_SQR};
                        S_DIV:  o_cmd = '{go: 1'b1, op: OP_DIV};
                        S_QMUL: o_cmd = '{go: 1'b1, op: OP_QMUL};
                        default: o_cmd = '{go: 1'b1, op: OP_MSG};
                    endcase
                    if (r_state == S_RED && i_status.mod_zero) begin
                        n_issued = 1'b0;
                        o_cmd.go = 1'b0;
                        n_fail   = 1'b1;
                        n_state  = S_OUT;
                    end
                end else if (i_status.done) begin
                    n_issued = 1'b0;
                    priority case (r_state)
                        S_RED:  n_state = S_EXP;
                        S_MUL:  n_state = S_SQR;
                        S_SQR:  n_state = S_EXP;
                        S_DIV:  n_state = S_QMUL;
                        S_QMUL: begin
                            o_cmd   = '{go: 1'b1, op: OP_STEP};
                            n_state = S_EUC;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_EXP: begin
                if (i_status.exp_zero) begin
                    o_cmd   = '{go: 1'b1, op: OP_STEP};
                    n_state = S_EUC;
                end else if (i_status.exp_bit) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_EUC: begin
                n_state = i_status.r1_zero ? S_FIN : S_DIV;
            end
            S_FIN: begin
                if (i_status.r0_one) begin
                    n_state = S_MSG;
                end else begin
                    n_fail  = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_fail   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            r_fail   <= n_fail;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_fail = r_fail;
endmodule

### src/egd_datapath.sv
// Datapath of the ElGamal decryption unit: operand registers, a bit-serial
// modular multiplier and a restoring divider. Depends on egd_pkg.
module egd_datapath #(
    parameter int unsigned WORD_BITS = egd_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  egd_pkg::t_cmd              i_cmd,
    input  logic                       i_fail,
    input  logic [WORD_BITS-1:0]       i_modulus,
    input  logic [WORD_BITS-1:0]       i_exponent,
    input  logic [WORD_BITS-1:0]       i_c1,
    input  logic [WORD_BITS-1:0]       i_c2,
    output egd_pkg::t_status           o_status,
    output logic [WORD_BITS-1:0]       o_message
);
    import egd_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(WORD_BITS + 1);

    logic [WORD_BITS-1:0] r_m, r_e, r_base, r_acc, r_c2;
    logic [WORD_BITS-1:0] r_r0, r_r1, r_t0, r_t1, r_q;
    // Shared unit: r_ua multiplicand or divisor, r_ub multiplier or dividend bits,
    // r_ur product or partial remainder.
    logic [WORD_BITS-1:0] r_ua, r_ub, r_ur;
    logic [CNT_BITS-1:0]  r_cnt;
    logic                 r_run, r_done;
    logic [OP_BITS-1:0]   r_op;

    logic [WORD_BITS-1:0] w_add_aa, w_add_ra, w_sh;
    logic [WORD_BITS:0]   w_rem2, w_sum;
    logic [WORD_BITS-1:0] w_prod, w_tsub;

    function automatic logic [WORD_BITS-1:0] add_mod(
        input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b,
        input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

    assign w_add_aa = add_mod(r_ua, r_ua, r_m);
    assign w_add_ra = add_mod(r_ur, r_ua, r_m);
    assign w_rem2 = {r_ur, r_ub[WORD_BITS-1]};
    assign w_sum = w_rem2 - {1'b0, r_ua};
    assign w_sh = {r_ub[WORD_BITS-2:0], ~w_sum[WORD_BITS]};
    assign w_prod = r_ur;
    assign w_tsub = (r_t0 >= w_prod) ? (r_t0 - w_prod) : (r_t0 + (r_m - w_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= OP_LOAD;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.go) begin
                r_op <= i_cmd.op;
                unique case (i_cmd.op)
                    OP_LOAD: begin
                        r_m    <= i_modulus;
                        r_e    <= i_exponent;
                        r_base <= i_c1;
                        r_c2   <= i_c2;
                    end
                    OP_REDUCE, OP_DIV: begin
                        // Long division of r_ub by r_ua: quotient in r_ub, rest in r_ur.
                        r_ua  <= (i_cmd.op == OP_REDUCE) ? r_m : r_r1;
                        r_ub  <= (i_cmd.op == OP_REDUCE) ? r_base : r_r0;
                        r_ur  <= '0;
                        r_cnt <= CNT_BITS'(WORD_BITS);
                        r_run <= 1'b1;
                    end
                    OP_MUL, OP_SQR, OP_QMUL, OP_MSG: begin
                        r_ur  <= '0;
                        r_cnt <= CNT_BITS'(WORD_BITS);
                        r_run <= 1'b1;
                        priority case (i_cmd.op)
                            OP_MUL: begin
                                r_ua <= r_base;
                                r_ub <= r_acc;
                            end
                            OP_SQR: begin
                                r_ua <= r_base;
                                r_ub <= r_base;
                            end
                            OP_QMUL: begin
                                r_ua <= r_t1;
                                r_ub <= r_q;
                            end
                            default: begin
                                r_ua <= r_t0;
                                r_ub <= r_c2;
                            end
                        endcase
                    end
                    OP_STEP: begin
                        if (r_op == OP_QMUL) begin
                            r_t0 <= r_t1;
                            r_t1 <= w_tsub;
                        end else begin
                            r_r0 <= r_m;
                            r_r1 <= r_acc;
                            r_t0 <= '0;
                            r_t1 <= (r_m == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                        end
                    end
                    default: ;
                endcase
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_op == OP_REDUCE || r_op == OP_DIV) begin
                    r_ur <= w_sum[WORD_BITS] ? w_rem2[WORD_BITS-1:0]
                                             : w_sum[WORD_BITS-1:0];
                    r_ub <= w_sh;
                end else begin
                    if (r_ub[0]) begin
                        r_ur <= w_add_ra;
                    end
                    r_ua <= w_add_aa;
                    r_ub <= r_ub >> 1;
                end
                if (r_cnt == CNT_BITS'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_done) begin
                unique case (r_op)
                    OP_REDUCE: begin
                        r_base <= r_ur;
                        r_acc  <= (r_m == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                    end
                    OP_MUL: r_acc <= r_ur;
                    OP_SQR: begin
                        r_base <= r_ur;
                        r_e    <= r_e >> 1;
                    end
                    OP_DIV: begin
                        r_r0 <= r_r1;
                        r_r1 <= r_ur;
                        // q mod m for the coefficient update.
                        r_q  <= (r_ub >= r_m) ? (r_ub - r_m) : r_ub;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_status = '{
        done:     r_done,
        mod_zero: (r_m == '0),
        exp_zero: (r_e == '0),
        exp_bit:  r_e[0],
        r1_zero:  (r_r1 == '0),
        r0_one:   (r_r0 == WORD_BITS'(1))
    };
    assign o_message = i_fail ? '0 : r_ur;
endmodule

### src/elgamal_decrypt.sv
// ElGamal decryption unit, top level: configuration registers, controller
// and datapath. Depends on egd_pkg, egd_ctrl, egd_datapath, elgamal_decrypt_assert.svh.
//
// One item (c1, c2) is accepted when i_start is high and o_busy low; o_busy
// then stays high until the result strobe o_valid, which lasts one cycle and
// cannot be stalled. All multiplies and divisions run one bit a cycle on
// one shared modular multiply and divide unit, and each exponent bit and each
// Euclid step also passes through a decision state. The run time of an item
// grows with the bit length of the exponent, its set bits and the Euclid
// steps; a missing inverse skips the final message multiply and a zero
// modulus fails the item before any multiply or division runs.
`include "elgamal_decrypt_assert.svh"
module elgamal_decrypt #(
    parameter int unsigned WORD_BITS = egd_pkg::WORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [egd_pkg::IDX_BITS-1:0]    i_cfg_index,
    input  logic [egd_pkg::REG_BITS-1:0]    i_cfg_data,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [31:0]                     i_first_part,
    input  logic [31:0]                     i_second_part,
    output logic                            o_valid,
    output logic [31:0]                     o_message,
    output logic                            o_failed
);
    import egd_pkg::*;

    logic [REG_BITS-1:0]  r_modulus, r_exponent;
    t_cmd                 w_cmd;
    t_status              w_status;
    logic                 w_fail;
    logic [WORD_BITS-1:0] w_msg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= MODULUS_RESET;
            r_exponent <= EXPONENT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MODULUS:  r_modulus  <= i_cfg_data;
                REG_EXPONENT: r_exponent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    egd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid),
        .o_fail   (w_fail)
    );

    egd_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_fail     (w_fail),
        .i_modulus  (WORD_BITS'(r_modulus)),
        .i_exponent (WORD_BITS'(r_exponent)),
        .i_c1       (WORD_BITS'(i_first_part)),
        .i_c2       (WORD_BITS'(i_second_part)),
        .o_status   (w_status),
        .o_message  (w_msg)
    );

    assign o_message = 32'(w_msg);
    assign o_failed  = w_fail;

    `EGD_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy, "start not taken")
    `EGD_ASSERT_IMP(a_fail_zero, i_clk, i_rst_n, o_valid && o_failed, o_message == '0, "failed with message")
    `EGD_ASSERT_NXT(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy, "busy after result")
endmodule
